/* hdl/tqds_pkg.sv */
// shared types, constants and helpers of the two-queue dual-server scheduler
`default_nettype none

package tqds_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int KIND_W    = 2;
    localparam int ID_W      = 16;
    localparam int STAMP_W   = 32;
    localparam int LIMIT_W   = 5;
    localparam int COUNT_W   = 5;
    localparam int SUM_W     = 32;
    localparam int ACTV_W    = 16;
    localparam int ACTION_W  = 2;
    localparam int ENTRY_W   = ID_W + STAMP_W;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 160;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRIO = 2'd0,
        KIND_NORM = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_IDLE = 2'd0,
        ACT_PRIO = 2'd1,
        ACT_NORM = 2'd2
    } action_t;

    typedef enum logic {
        Q_PRIO = 1'b0,
        Q_NORM = 1'b1
    } queue_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_REQ    = 2'd1,
        ST_SERVE1 = 2'd2,
        ST_SERVE2 = 2'd3
    } state_t;

    typedef struct packed {
        logic   latch;
        logic   exec_req;
        logic   serve;
        queue_t serve_q;
        logic   second;
        logic   load_out;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic p_busy;
        logic n_busy;
        logic mode;
        logic out_free;
    } status_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int cnt_w(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

`default_nettype wire

/* hdl/tqds_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module tqds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = tqds_pkg::addr_w(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/tqds_ctrl.sv */
// controller state machine: sequences requests and the two pops of a tick
`default_nettype none

module tqds_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tqds_pkg::status_t status,
    output tqds_pkg::cmd_t         cmd
);

    tqds_pkg::state_t state_reg, state_next;
    tqds_pkg::queue_t q2_reg, q2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tqds_pkg::ST_IDLE;
            q2_reg    <= tqds_pkg::Q_PRIO;
        end else begin
            state_reg <= state_next;
            q2_reg    <= q2_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        q2_next      = q2_reg;
        s_tready     = 1'b0;
        cmd.latch    = 1'b0;
        cmd.exec_req = 1'b0;
        cmd.serve    = 1'b0;
        cmd.serve_q  = tqds_pkg::Q_PRIO;
        cmd.second   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            tqds_pkg::ST_IDLE: begin
                s_tready  = status.out_free;
                cmd.latch = s_tvalid && status.out_free;
                if (cmd.latch) begin
                    state_next = status.in_tick ? tqds_pkg::ST_SERVE1 : tqds_pkg::ST_REQ;
                end
            end
            tqds_pkg::ST_REQ: begin
                cmd.exec_req = 1'b1;
                cmd.load_out = 1'b1;
                state_next   = tqds_pkg::ST_IDLE;
            end
            tqds_pkg::ST_SERVE1: begin
                // an empty chosen queue yields an idle slot in the datapath
                cmd.serve = 1'b1;
                if (!status.mode && !status.p_busy && status.n_busy) begin
                    cmd.serve_q = tqds_pkg::Q_NORM;
                end
                if (!status.mode && (status.n_busy && (status.p_busy || !status.p_busy))
                    && !(status.p_busy && !status.n_busy)) begin
                    q2_next = tqds_pkg::Q_NORM;
                end else begin
                    q2_next = tqds_pkg::Q_PRIO;
                end
                state_next = tqds_pkg::ST_SERVE2;
            end
            tqds_pkg::ST_SERVE2: begin
                cmd.serve    = 1'b1;
                cmd.serve_q  = q2_reg;
                cmd.second   = 1'b1;
                cmd.load_out = 1'b1;
                state_next   = tqds_pkg::ST_IDLE;
            end
            default: begin
                state_next = tqds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tqds_dpath.sv */
// datapath: queue pointers and stores, accumulators, result register
`default_nettype none

module tqds_dpath #(
    parameter int QUEUE_DEPTH = tqds_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [tqds_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [tqds_pkg::KIND_W-1:0]     s_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [tqds_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic      [tqds_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire tqds_pkg::cmd_t                  cmd,
    output tqds_pkg::status_t                    status
);

    localparam int AW = tqds_pkg::addr_w(QUEUE_DEPTH);
    localparam int CW = tqds_pkg::cnt_w(QUEUE_DEPTH);
    localparam int LW = (CW > tqds_pkg::LIMIT_W) ? CW : tqds_pkg::LIMIT_W;
    localparam int IW = tqds_pkg::ID_W;
    localparam int TW = tqds_pkg::STAMP_W;
    localparam int SW = tqds_pkg::SUM_W;
    localparam int VW = tqds_pkg::ACTV_W;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // latched item
    tqds_pkg::kind_t kind_reg;
    logic [IW-1:0]   id_reg;
    logic [TW-1:0]   stamp_reg;

    logic [tqds_pkg::LIMIT_W-1:0] limit_reg;

    logic [AW-1:0] p_head_reg, p_head_next, p_tail_reg, p_tail_next;
    logic [AW-1:0] n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [CW-1:0] p_fill_reg, p_fill_next, n_fill_reg, n_fill_next;
    logic          mode_reg, mode_next;
    logic [SW-1:0] pws_reg, pws_next, nws_reg, nws_next, idle_reg, idle_next;
    logic [VW-1:0] actv_reg, actv_next;

    tqds_pkg::action_t act1_reg, act1_next;
    logic [IW-1:0]     id1_reg, id1_next;

    logic                          out_valid_reg, out_valid_next;
    logic [tqds_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic [tqds_pkg::ENTRY_W-1:0] p_rdata, n_rdata, srv_entry;
    logic                         p_we, n_we;
    logic [LW-1:0]                lim;
    logic                         p_full, n_full, srv_ne, pop, acc;
    logic [TW-1:0]                srv_arr, srv_wait;
    logic [SW-1:0]                srv_base, srv_sum;
    logic [SW:0]                  srv_sum_wide;
    logic [IW-1:0]                srv_id;
    tqds_pkg::action_t            srv_act, a1, a2;
    logic [IW-1:0]                i1, i2;
    logic [31:0]                  p_cnt_wide, n_cnt_wide;

    tqds_ram #(.WIDTH(tqds_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_p_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_tail_reg),
        .wdata ({id_reg, stamp_reg}),
        .raddr (p_head_next),
        .rdata (p_rdata)
    );

    tqds_ram #(.WIDTH(tqds_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_n_ram (
        .aclk  (aclk),
        .we    (n_we),
        .waddr (n_tail_reg),
        .wdata ({id_reg, stamp_reg}),
        .raddr (n_head_next),
        .rdata (n_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= tqds_pkg::LIMIT_RESET;
            p_head_reg    <= '0;
            p_tail_reg    <= '0;
            p_fill_reg    <= '0;
            n_head_reg    <= '0;
            n_tail_reg    <= '0;
            n_fill_reg    <= '0;
            mode_reg      <= 1'b0;
            pws_reg       <= '0;
            nws_reg       <= '0;
            idle_reg      <= '0;
            actv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            p_head_reg    <= p_head_next;
            p_tail_reg    <= p_tail_next;
            p_fill_reg    <= p_fill_next;
            n_head_reg    <= n_head_next;
            n_tail_reg    <= n_tail_next;
            n_fill_reg    <= n_fill_next;
            mode_reg      <= mode_next;
            pws_reg       <= pws_next;
            nws_reg       <= nws_next;
            idle_reg      <= idle_next;
            actv_reg      <= actv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg  <= tqds_pkg::kind_t'(s_tuser);
            id_reg    <= s_tdata[IW-1:0];
            stamp_reg <= s_tdata[IW+TW-1:IW];
        end
        act1_reg     <= act1_next;
        id1_reg      <= id1_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        lim    = (LW'(limit_reg) < LW'(QUEUE_DEPTH)) ? LW'(limit_reg) : LW'(QUEUE_DEPTH);
        p_full = LW'(p_fill_reg) >= lim;
        n_full = LW'(n_fill_reg) >= lim;

        srv_entry    = (cmd.serve_q == tqds_pkg::Q_NORM) ? n_rdata : p_rdata;
        srv_ne       = (cmd.serve_q == tqds_pkg::Q_NORM) ? (n_fill_reg != '0)
                                                         : (p_fill_reg != '0);
        srv_arr      = srv_entry[TW-1:0];
        srv_id       = srv_entry[TW+IW-1:TW];
        srv_wait     = (stamp_reg >= srv_arr) ? stamp_reg - srv_arr : '0;
        srv_base     = (cmd.serve_q == tqds_pkg::Q_NORM) ? nws_reg : pws_reg;
        srv_sum_wide = {1'b0, srv_base} + {1'b0, srv_wait};
        srv_sum      = srv_sum_wide[SW] ? '1 : srv_sum_wide[SW-1:0];
        pop          = cmd.serve && srv_ne;
        if (!pop) begin
            srv_act = tqds_pkg::ACT_IDLE;
        end else if (cmd.serve_q == tqds_pkg::Q_NORM) begin
            srv_act = tqds_pkg::ACT_NORM;
        end else begin
            srv_act = tqds_pkg::ACT_PRIO;
        end

        p_head_next = p_head_reg;
        p_tail_next = p_tail_reg;
        p_fill_next = p_fill_reg;
        n_head_next = n_head_reg;
        n_tail_next = n_tail_reg;
        n_fill_next = n_fill_reg;
        mode_next   = mode_reg;
        pws_next    = pws_reg;
        nws_next    = nws_reg;
        idle_next   = idle_reg;
        actv_next   = actv_reg;
        act1_next   = act1_reg;
        id1_next    = id1_reg;
        p_we        = 1'b0;
        n_we        = 1'b0;
        acc         = 1'b0;

        if (cmd.exec_req) begin
            case (kind_reg)
                tqds_pkg::KIND_PRIO: begin
                    if (!p_full) begin
                        p_we        = 1'b1;
                        acc         = 1'b1;
                        p_tail_next = ptr_inc(p_tail_reg);
                        p_fill_next = p_fill_reg + CW'(1);
                    end else begin
                        mode_next = 1'b1;
                        if (actv_reg != '1) begin
                            actv_next = actv_reg + VW'(1);
                        end
                    end
                end
                tqds_pkg::KIND_NORM: begin
                    if (!n_full) begin
                        n_we        = 1'b1;
                        acc         = 1'b1;
                        n_tail_next = ptr_inc(n_tail_reg);
                        n_fill_next = n_fill_reg + CW'(1);
                    end
                end
                default: begin
                    acc = 1'b0;
                end
            endcase
        end

        if (pop) begin
            if (cmd.serve_q == tqds_pkg::Q_NORM) begin
                n_head_next = ptr_inc(n_head_reg);
                n_fill_next = n_fill_reg - CW'(1);
                nws_next    = srv_sum;
            end else begin
                p_head_next = ptr_inc(p_head_reg);
                p_fill_next = p_fill_reg - CW'(1);
                pws_next    = srv_sum;
            end
        end else if (cmd.serve && idle_reg != '1) begin
            idle_next = idle_reg + SW'(1);
        end

        if (cmd.serve && !cmd.second) begin
            act1_next = srv_act;
            id1_next  = pop ? srv_id : '0;
        end

        if (cmd.second && mode_reg && p_fill_next == '0) begin
            mode_next = 1'b0;
        end

        a1 = cmd.second ? act1_reg : tqds_pkg::ACT_IDLE;
        i1 = cmd.second ? id1_reg : '0;
        a2 = cmd.second ? srv_act : tqds_pkg::ACT_IDLE;
        i2 = (cmd.second && pop) ? srv_id : '0;

        p_cnt_wide = 32'(p_fill_next);
        n_cnt_wide = 32'(n_fill_next);

        out_data_next = out_data_reg;
        if (cmd.load_out) begin
            out_data_next = {actv_next, idle_next, nws_next, pws_next,
                             n_cnt_wide[tqds_pkg::COUNT_W-1:0],
                             p_cnt_wide[tqds_pkg::COUNT_W-1:0],
                             mode_next, i2, a2, i1, a1, acc};
        end

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        status.in_tick  = (tqds_pkg::kind_t'(s_tuser) == tqds_pkg::KIND_TICK);
        status.p_busy   = (p_fill_reg != '0);
        status.n_busy   = (n_fill_reg != '0);
        status.mode     = mode_reg;
        status.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/two_queue_dual_server_scheduler.sv */
// top level of the two-queue dual-server scheduler
// Two bounded fifos, a priority class and a normal class, hold request ids
// with their arrival stamps; a request word is queued while its queue holds
// fewer entries than the lesser of the limit register and QUEUE_DEPTH, and a
// refused priority request raises priority mode and bumps the activation
// count. A tick word lets two servers pop one entry each (both from the
// priority queue in priority mode, else one per class when both hold entries,
// else both from the busy one), adding saturating waits and idle-slot counts.
// Every input word gives exactly one result word carrying the status after it.
// A request word (or an unused kind) passes ST_REQ from acceptance to result,
// a tick word ST_SERVE1 and ST_SERVE2, as both pops may hit the same queue ram
// whose single read port gives one entry per cycle. One word is in flight at
// a time; the next is taken once the result register is free or draining.
// The queue stores need no clearing pass after reset: only written entries
// are ever read. The limit register may be written only while the block is idle.
`default_nettype none

module two_queue_dual_server_scheduler #(
    parameter int QUEUE_DEPTH = tqds_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // request_id[15:0], stamp[47:16]
    input  wire logic [tqds_pkg::S_DATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire logic [tqds_pkg::KIND_W-1:0]   s_tuser,
    // queue limit register
    input  wire logic                          cfg_we,
    input  wire logic [tqds_pkg::LIMIT_W-1:0]  cfg_wdata,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // accepted[0], first_action[2:1], first_id[18:3], second_action[20:19],
    // second_id[36:21], priority_mode[37], priority_count[42:38],
    // normal_count[47:43], priority_wait_total[79:48],
    // normal_wait_total[111:80], idle_slots_total[143:112],
    // activation_total[159:144]
    output logic      [tqds_pkg::M_DATA_W-1:0] m_tdata
);

    // command and status between sequencer and datapath
    tqds_pkg::cmd_t    cmd;
    tqds_pkg::status_t status;

    tqds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tqds_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

/* hdl/tqds_checker.sv */
// port-level checks of the scheduler, bound to the top level
`default_nettype none

module tqds_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tqds_pkg::M_DATA_W-1:0] m_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: the result register is empty right after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result shown too early after acceptance");

    // an idle first server reports id zero
    a_idle_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:1] == tqds_pkg::ACT_IDLE |-> m_tdata[18:3] == '0)
        else $error("idle first server with nonzero id");

    // a queued request never serves
    a_acc_no_serve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            m_tdata[2:1] == tqds_pkg::ACT_IDLE && m_tdata[20:19] == tqds_pkg::ACT_IDLE)
        else $error("accepted request with server action");

    // first server idle means nothing was left for the second
    a_idle_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:1] == tqds_pkg::ACT_IDLE |->
            m_tdata[20:19] == tqds_pkg::ACT_IDLE)
        else $error("second server busy while first idle");

endmodule

bind two_queue_dual_server_scheduler tqds_checker u_tqds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
